@@ hw/rtl/snk_pkg.sv @@
// ----------------------------------------------------------------------------
// snk_pkg: shared types and constants of the Sinkhorn normalizer
// Widths, configuration register indexes, sequencer states and the exp table.
// ----------------------------------------------------------------------------
package snk_pkg;

  localparam int MATRIX_DIM  = 4;
  localparam int ENTRY_COUNT = MATRIX_DIM * MATRIX_DIM;
  localparam int IDX_W       = $clog2(ENTRY_COUNT);
  localparam int DIM_W       = $clog2(MATRIX_DIM);

  localparam int LOGIT_W   = 16;
  localparam int VAL_W     = 24;
  localparam int SUM_W     = 27;
  localparam int ACC_W     = VAL_W + $clog2(MATRIX_DIM + 1) + 1;
  localparam int RND_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;

  localparam int DIV_SHIFT = 22;
  localparam int QUO_W     = VAL_W + DIV_SHIFT;
  localparam int REM_W     = SUM_W;

  localparam int FRAC_BITS = 24;
  localparam int FIDX_W    = $clog2(FRAC_BITS);
  localparam int P_W       = 31;
  localparam int LOG2E_W   = 17;
  localparam int U_W       = LOGIT_W + LOG2E_W;
  localparam int IP_W      = U_W - FRAC_BITS;
  localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUND_COUNT = 1'b0,
    CFG_EPSILON     = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MAX,
    ST_EXP_GO,
    ST_EXP_WAIT,
    ST_SDIV_GO,
    ST_SDIV_WAIT,
    ST_LSUM,
    ST_LDIV_GO,
    ST_LDIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef logic [P_W-1:0] pow_tab_t [FRAC_BITS];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] rem;
    logic [63:0] b;
    r   = '0;
    rem = v;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // entry k holds 2^(-2^-(k+1)) in Q30
  function automatic pow_tab_t build_tab();
    pow_tab_t    t;
    logic [63:0] x;
    x = 64'd1 << 29;
    for (int k = 0; k < FRAC_BITS; k++) begin
      x    = isqrt64(x << 30);
      t[k] = P_W'(x);
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = build_tab();

endpackage

@@ hw/rtl/snk_in_if.sv @@
// ----------------------------------------------------------------------------
// snk_in_if: logit input channel
// Valid/ready channel carrying one logit and the batch end flag.
// ----------------------------------------------------------------------------
interface snk_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [snk_pkg::LOGIT_W-1:0]   logit;
  logic                                 batch_end;

  modport source (output valid, output logit, output batch_end, input ready);
  modport sink   (input valid, input logit, input batch_end, output ready);
endinterface

@@ hw/rtl/snk_out_if.sv @@
// ----------------------------------------------------------------------------
// snk_out_if: normalized value output channel
// Valid/ready channel carrying one normalized entry and its end markers.
// ----------------------------------------------------------------------------
interface snk_out_if;
  logic                        valid;
  logic                        ready;
  logic [snk_pkg::VAL_W-1:0]   normalized_value;
  logic                        last;
  logic                        batch_done;

  modport source (output valid, output normalized_value, output last,
                  output batch_done, input ready);
  modport sink   (input valid, input normalized_value, input last,
                  input batch_done, output ready);
endinterface

@@ hw/rtl/snk_exp.sv @@
// ----------------------------------------------------------------------------
// snk_exp: iterative exponential unit
// exp(-n) for n in Q8.8, result Q2.22; one table multiply per cycle.
// ----------------------------------------------------------------------------
module snk_exp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [snk_pkg::LOGIT_W-1:0]  n_i,
  output snk_pkg::unit_stat_t          stat_o,
  output logic [snk_pkg::VAL_W-1:0]    res_o
);

  logic [snk_pkg::U_W-1:0]    u_q, u_d;
  logic [snk_pkg::P_W-1:0]    p_q, p_d;
  logic [snk_pkg::FIDX_W-1:0] k_q, k_d;
  logic                       busy_q, busy_d, done_q, done_d;

  logic [snk_pkg::FRAC_BITS-1:0] frac;
  logic [2*snk_pkg::P_W-1:0]     prod;
  logic [snk_pkg::IP_W-1:0]      ip;

  assign frac = u_q[snk_pkg::FRAC_BITS-1:0];
  assign ip   = u_q[snk_pkg::U_W-1:snk_pkg::FRAC_BITS];
  assign prod = (2*snk_pkg::P_W)'(p_q) * (2*snk_pkg::P_W)'(snk_pkg::POW_TAB[k_q]);

  always_comb begin
    u_d    = u_q;
    p_d    = p_q;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      u_d    = snk_pkg::U_W'(n_i) * snk_pkg::U_W'(snk_pkg::LOG2E_Q16);
      p_d    = snk_pkg::P_W'(1) << 30;
      k_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (frac[snk_pkg::FIDX_W'(snk_pkg::FRAC_BITS - 1) - k_q]) begin
        p_d = snk_pkg::P_W'(prod >> 30);
      end
      if (k_q == snk_pkg::FIDX_W'(snk_pkg::FRAC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        k_d = k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    p_q <= p_d;
  end

  // drop to zero once the shift clears every bit of the product
  always_comb begin
    if (ip > snk_pkg::IP_W'(snk_pkg::P_W - 1 - 8)) begin
      res_o = '0;
    end else begin
      res_o = snk_pkg::VAL_W'(p_q >> (ip + snk_pkg::IP_W'(8)));
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ hw/rtl/snk_div.sv @@
// ----------------------------------------------------------------------------
// snk_div: restoring divider
// floor((x << 22) / d), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module snk_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [snk_pkg::VAL_W-1:0]   x_i,
  input  logic [snk_pkg::SUM_W-1:0]   d_i,
  output snk_pkg::unit_stat_t         stat_o,
  output logic [snk_pkg::QUO_W-1:0]   quo_o
);

  localparam int CNT_W = $clog2(snk_pkg::QUO_W);

  logic [snk_pkg::REM_W-1:0] rem_q, rem_d;
  logic [snk_pkg::QUO_W-1:0] n_q, n_d;
  logic [snk_pkg::SUM_W-1:0] d_q, d_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [snk_pkg::REM_W:0]   trial;
  logic                      fits;

  assign trial = {rem_q, n_q[snk_pkg::QUO_W-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_comb begin
    rem_d  = rem_q;
    n_d    = n_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      n_d    = {x_i, {snk_pkg::DIV_SHIFT{1'b0}}};
      d_d    = d_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? snk_pkg::REM_W'(trial - {1'b0, d_q})
                   : snk_pkg::REM_W'(trial);
      n_d   = {n_q[snk_pkg::QUO_W-2:0], fits};
      if (cnt_q == CNT_W'(snk_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    n_q   <= n_d;
    d_q   <= d_d;
  end

  assign quo_o       = n_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ hw/rtl/sinkhorn_normalize_4x4_unit.sv @@
// Sequence: load 16 entries, then compute (round_count zero counts as one; a
// zero divisor skips its divider wait), then output 16 entries; the 46-step
// divider sets most of the compute time.
// Throughput: one matrix at a time; input ready only while loading.
// Reset: asynchronous, active low; clears the sequencer and counters, loads
// round_count = 1 and epsilon = 4. The matrix store is not cleared.
// ----------------------------------------------------------------------------
// sinkhorn_normalize_4x4_unit: Sinkhorn normalizer top level
// Sequencer over a matrix store, a shared exp unit and a shared divider.
// ----------------------------------------------------------------------------
module sinkhorn_normalize_4x4_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  snk_in_if.sink                         in_i,
  snk_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [snk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [snk_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam logic [snk_pkg::DIM_W-1:0] DIM_LAST = snk_pkg::DIM_W'(snk_pkg::MATRIX_DIM - 1);
  localparam logic [snk_pkg::IDX_W-1:0] IDX_LAST = snk_pkg::IDX_W'(snk_pkg::ENTRY_COUNT - 1);

  snk_pkg::state_e state_q, state_d;

  logic [snk_pkg::VAL_W-1:0] store_q [snk_pkg::ENTRY_COUNT];
  logic [snk_pkg::SUM_W-1:0] lsum_q  [snk_pkg::MATRIX_DIM];

  logic [snk_pkg::RND_W-1:0]         rcount_q;
  logic [snk_pkg::VAL_W-1:0]         eps_q;
  logic [snk_pkg::IDX_W-1:0]         k_q, k_d;
  logic [snk_pkg::DIM_W-1:0]         a_q, a_d, b_q, b_d;
  logic                              by_row_q, by_row_d;
  logic [snk_pkg::RND_W-1:0]         rnd_q, rnd_d;
  logic signed [snk_pkg::LOGIT_W-1:0] mx_q, mx_d;
  logic [snk_pkg::ACC_W-1:0]         sum_q, sum_d;
  logic                              batch_q, batch_d;

  logic                      wr_en, lsum_we;
  logic [snk_pkg::IDX_W-1:0] wr_idx;
  logic [snk_pkg::VAL_W-1:0] wr_data;
  logic [snk_pkg::SUM_W-1:0] lsum_data;

  logic [snk_pkg::IDX_W-1:0]          idx;
  logic [snk_pkg::VAL_W-1:0]          rd;
  logic signed [snk_pkg::LOGIT_W-1:0] v;
  logic [snk_pkg::SUM_W-1:0]          sum_sat, line_d;
  logic [snk_pkg::ACC_W-1:0]          acc;
  logic [snk_pkg::VAL_W:0]            e_eps;
  logic [snk_pkg::VAL_W:0]            q_eps;
  logic [snk_pkg::VAL_W-1:0]          q_sat;

  logic                       exp_start, div_start, line_is_soft;
  logic [snk_pkg::LOGIT_W-1:0] exp_n;
  logic [snk_pkg::VAL_W-1:0]  exp_res;
  logic [snk_pkg::QUO_W-1:0]  quo;
  logic [snk_pkg::SUM_W-1:0]  div_d;
  snk_pkg::unit_stat_t        exp_stat, div_stat;

  snk_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .n_i     (exp_n),
    .stat_o  (exp_stat),
    .res_o   (exp_res)
  );

  snk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (rd),
    .d_i     (div_d),
    .stat_o  (div_stat),
    .quo_o   (quo)
  );

  assign idx = by_row_q
             ? snk_pkg::IDX_W'(a_q) * snk_pkg::IDX_W'(snk_pkg::MATRIX_DIM) + snk_pkg::IDX_W'(b_q)
             : snk_pkg::IDX_W'(b_q) * snk_pkg::IDX_W'(snk_pkg::MATRIX_DIM) + snk_pkg::IDX_W'(a_q);
  assign rd      = store_q[idx];
  assign v       = rd[snk_pkg::LOGIT_W-1:0];
  assign sum_sat = (sum_q > snk_pkg::ACC_W'(snk_pkg::SUM_MAX)) ? snk_pkg::SUM_MAX
                                                              : snk_pkg::SUM_W'(sum_q);
  assign acc     = sum_q + snk_pkg::ACC_W'(rd);
  assign line_d  = (acc > snk_pkg::ACC_W'(snk_pkg::SUM_MAX)) ? snk_pkg::SUM_MAX
                                                            : snk_pkg::SUM_W'(acc);
  assign line_is_soft = (state_q == snk_pkg::ST_SDIV_GO) || (state_q == snk_pkg::ST_SDIV_WAIT);
  assign div_d   = line_is_soft ? sum_sat : lsum_q[a_q];
  assign exp_n   = snk_pkg::LOGIT_W'(mx_q - v);
  assign e_eps   = {1'b0, rd} + {1'b0, eps_q};
  assign q_sat   = (quo > snk_pkg::QUO_W'(snk_pkg::VAL_MAX)) ? snk_pkg::VAL_MAX
                                                            : snk_pkg::VAL_W'(quo);
  assign q_eps   = {1'b0, q_sat} + {1'b0, eps_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      snk_pkg::ST_LOAD: begin
        if (in_i.valid && k_q == IDX_LAST) state_d = snk_pkg::ST_MAX;
      end
      snk_pkg::ST_MAX: begin
        if (b_q == DIM_LAST) state_d = snk_pkg::ST_EXP_GO;
      end
      snk_pkg::ST_EXP_GO: state_d = snk_pkg::ST_EXP_WAIT;
      snk_pkg::ST_EXP_WAIT: begin
        if (exp_stat.done) begin
          state_d = (b_q == DIM_LAST) ? snk_pkg::ST_SDIV_GO : snk_pkg::ST_EXP_GO;
        end
      end
      snk_pkg::ST_SDIV_GO, snk_pkg::ST_SDIV_WAIT: begin
        if ((state_q == snk_pkg::ST_SDIV_GO && sum_sat == '0) ||
            (state_q == snk_pkg::ST_SDIV_WAIT && div_stat.done)) begin
          if (b_q != DIM_LAST)      state_d = snk_pkg::ST_SDIV_GO;
          else if (a_q != DIM_LAST) state_d = snk_pkg::ST_MAX;
          else                      state_d = snk_pkg::ST_LSUM;
        end else if (state_q == snk_pkg::ST_SDIV_GO) begin
          state_d = snk_pkg::ST_SDIV_WAIT;
        end
      end
      snk_pkg::ST_LSUM: begin
        if (b_q == DIM_LAST && a_q == DIM_LAST) state_d = snk_pkg::ST_LDIV_GO;
      end
      snk_pkg::ST_LDIV_GO, snk_pkg::ST_LDIV_WAIT: begin
        if ((state_q == snk_pkg::ST_LDIV_GO && lsum_q[a_q] == '0) ||
            (state_q == snk_pkg::ST_LDIV_WAIT && div_stat.done)) begin
          if (b_q != DIM_LAST || a_q != DIM_LAST) state_d = snk_pkg::ST_LDIV_GO;
          else if (by_row_q || rnd_q < rcount_q)  state_d = snk_pkg::ST_LSUM;
          else                                    state_d = snk_pkg::ST_OUT;
        end else if (state_q == snk_pkg::ST_LDIV_GO) begin
          state_d = snk_pkg::ST_LDIV_WAIT;
        end
      end
      snk_pkg::ST_OUT: begin
        if (out_o.ready && k_q == IDX_LAST) state_d = snk_pkg::ST_LOAD;
      end
      default: state_d = snk_pkg::ST_LOAD;
    endcase
  end

  // datapath and outputs
  always_comb begin
    k_d       = k_q;
    a_d       = a_q;
    b_d       = b_q;
    by_row_d  = by_row_q;
    rnd_d     = rnd_q;
    mx_d      = mx_q;
    sum_d     = sum_q;
    batch_d   = batch_q;
    wr_en     = 1'b0;
    wr_idx    = idx;
    wr_data   = rd;
    lsum_we   = 1'b0;
    lsum_data = line_d;
    exp_start = 1'b0;
    div_start = 1'b0;
    in_i.ready             = 1'b0;
    out_o.valid            = 1'b0;
    out_o.normalized_value = store_q[k_q];
    out_o.last             = (k_q == IDX_LAST);
    out_o.batch_done       = (k_q == IDX_LAST) && batch_q;
    case (state_q)
      snk_pkg::ST_LOAD: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          wr_en   = 1'b1;
          wr_idx  = k_q;
          wr_data = snk_pkg::VAL_W'(unsigned'(in_i.logit));
          batch_d = batch_q | in_i.batch_end;
          if (k_q == IDX_LAST) begin
            k_d      = '0;
            a_d      = '0;
            b_d      = '0;
            by_row_d = 1'b1;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      snk_pkg::ST_MAX: begin
        if (b_q == '0 || v > mx_q) mx_d = v;
        if (b_q == DIM_LAST) begin
          b_d   = '0;
          sum_d = '0;
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      snk_pkg::ST_EXP_GO: exp_start = 1'b1;
      snk_pkg::ST_EXP_WAIT: begin
        if (exp_stat.done) begin
          wr_en   = 1'b1;
          wr_data = exp_res;
          sum_d   = sum_q + snk_pkg::ACC_W'(exp_res);
          b_d     = (b_q == DIM_LAST) ? '0 : b_q + 1'b1;
        end
      end
      snk_pkg::ST_SDIV_GO, snk_pkg::ST_SDIV_WAIT: begin
        if ((state_q == snk_pkg::ST_SDIV_GO && sum_sat == '0) ||
            (state_q == snk_pkg::ST_SDIV_WAIT && div_stat.done)) begin
          wr_en = 1'b1;
          if (state_q == snk_pkg::ST_SDIV_GO) begin
            wr_data = e_eps[snk_pkg::VAL_W] ? snk_pkg::VAL_MAX : e_eps[snk_pkg::VAL_W-1:0];
          end else begin
            wr_data = q_eps[snk_pkg::VAL_W] ? snk_pkg::VAL_MAX : q_eps[snk_pkg::VAL_W-1:0];
          end
          if (b_q != DIM_LAST) begin
            b_d = b_q + 1'b1;
          end else begin
            b_d = '0;
            if (a_q != DIM_LAST) begin
              a_d = a_q + 1'b1;
            end else begin
              // first column pass follows the softmax
              a_d      = '0;
              by_row_d = 1'b0;
              rnd_d    = snk_pkg::RND_W'(1);
              sum_d    = snk_pkg::ACC_W'(eps_q);
            end
          end
        end else if (state_q == snk_pkg::ST_SDIV_GO) begin
          div_start = 1'b1;
        end
      end
      snk_pkg::ST_LSUM: begin
        if (b_q == DIM_LAST) begin
          lsum_we = 1'b1;
          sum_d   = snk_pkg::ACC_W'(eps_q);
          b_d     = '0;
          a_d     = (a_q == DIM_LAST) ? '0 : a_q + 1'b1;
        end else begin
          sum_d = acc;
          b_d   = b_q + 1'b1;
        end
      end
      snk_pkg::ST_LDIV_GO, snk_pkg::ST_LDIV_WAIT: begin
        if ((state_q == snk_pkg::ST_LDIV_GO && lsum_q[a_q] == '0) ||
            (state_q == snk_pkg::ST_LDIV_WAIT && div_stat.done)) begin
          if (state_q == snk_pkg::ST_LDIV_WAIT) begin
            wr_en   = 1'b1;
            wr_data = q_sat;
          end
          if (b_q != DIM_LAST) begin
            b_d = b_q + 1'b1;
          end else begin
            b_d = '0;
            if (a_q != DIM_LAST) begin
              a_d = a_q + 1'b1;
            end else begin
              a_d   = '0;
              sum_d = snk_pkg::ACC_W'(eps_q);
              if (by_row_q) begin
                by_row_d = 1'b0;
              end else if (rnd_q < rcount_q) begin
                rnd_d    = rnd_q + 1'b1;
                by_row_d = 1'b1;
              end else begin
                k_d = '0;
              end
            end
          end
        end else if (state_q == snk_pkg::ST_LDIV_GO) begin
          div_start = 1'b1;
        end
      end
      snk_pkg::ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          if (k_q == IDX_LAST) begin
            k_d     = '0;
            batch_d = 1'b0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= snk_pkg::ST_LOAD;
      k_q      <= '0;
      a_q      <= '0;
      b_q      <= '0;
      by_row_q <= 1'b1;
      rnd_q    <= '0;
      batch_q  <= 1'b0;
      rcount_q <= snk_pkg::RND_W'(1);
      eps_q    <= snk_pkg::VAL_W'(4);
      for (int i = 0; i < snk_pkg::MATRIX_DIM; i++) lsum_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      a_q      <= a_d;
      b_q      <= b_d;
      by_row_q <= by_row_d;
      rnd_q    <= rnd_d;
      batch_q  <= batch_d;
      if (lsum_we) lsum_q[a_q] <= lsum_data;
      if (cfg_we_i) begin
        case (snk_pkg::cfg_idx_e'(cfg_idx_i))
          snk_pkg::CFG_ROUND_COUNT: rcount_q <= cfg_data_i[snk_pkg::RND_W-1:0];
          snk_pkg::CFG_EPSILON:     eps_q    <= cfg_data_i[snk_pkg::VAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    sum_q <= sum_d;
    if (wr_en) store_q[wr_idx] <= wr_data;
  end

  // never take a request while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_o.valid && in_i.ready))
    else $error("input ready while output valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_start |-> !exp_stat.busy)
    else $error("exp unit started while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> (state_q == snk_pkg::ST_LOAD))
    else $error("sequencer did not return to load after last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == snk_pkg::ST_OUT) |-> !wr_en)
    else $error("store written during output");

endmodule
